// ----- sv/ttsk_pkg.sv -----
package ttsk_pkg;

  localparam int STACK_LEVELS_DEF = 64;
  localparam int FRAC_BITS_DEF    = 16;

  // constants held in Q30
  localparam longint Q30_COS30  = 64'sd929887697;
  localparam longint Q30_SIN30  = 64'sd536870912;
  localparam longint Q30_SHRINK = 64'sd966367642;
  localparam longint Q30_GROW   = 64'sd1193046471;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_X     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y     = 2'd2;

  localparam logic [30:0]        BASE_SCALE_RST = 31'd393216;
  localparam logic signed [31:0] BASE_X_RST     = 32'sd26214400;
  localparam logic signed [31:0] BASE_Y_RST     = 32'sd39321600;

  localparam logic [7:0] SYM_LEAF   = 8'h4C; // L
  localparam logic [7:0] SYM_STEM   = 8'h54; // T
  localparam logic [7:0] SYM_PLUS   = 8'h2B;
  localparam logic [7:0] SYM_MINUS  = 8'h2D;
  localparam logic [7:0] SYM_SHRINK = 8'h73; // s
  localparam logic [7:0] SYM_GROW   = 8'h53; // S
  localparam logic [7:0] SYM_HSHR   = 8'h68; // h
  localparam logic [7:0] SYM_HGRW   = 8'h48; // H
  localparam logic [7:0] SYM_VSHR   = 8'h76; // v
  localparam logic [7:0] SYM_VGRW   = 8'h56; // V
  localparam logic [7:0] SYM_PUSH   = 8'h5B; // [
  localparam logic [7:0] SYM_POP    = 8'h5D; // ]

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_LEAF = 2'd1;
  localparam logic [1:0] KIND_STEM = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_START, OP_LEAF, OP_STEM, OP_ROT_P, OP_ROT_N,
    OP_SHR, OP_GRW, OP_HSHR, OP_HGRW, OP_VSHR, OP_VGRW, OP_PUSH, OP_POP
  } op_e;

  typedef struct packed {
    logic signed [31:0] xx;
    logic signed [31:0] xy;
    logic signed [31:0] yx;
    logic signed [31:0] yy;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } mat_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_sts_t;

  function automatic logic signed [31:0] from_q30(longint c, int f);
    longint r;
    r = (c + (64'sd1 <<< (29 - f))) >>> (30 - f);
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round((x1*k1 + x2*k2) / 2^f + a), ties up, saturated
  function automatic logic signed [31:0] mac(logic signed [31:0] x1,
                                             logic signed [31:0] k1,
                                             logic signed [31:0] x2,
                                             logic signed [31:0] k2,
                                             logic signed [31:0] a, int f);
    logic signed [63:0] s;
    s = 64'(x1) * 64'(k1) + 64'(x2) * 64'(k2) + (64'(a) <<< f)
        + (64'sd1 <<< (f - 1));
    return sat32(s >>> f);
  endfunction

endpackage

// ----- sv/ttsk_stack.sv -----
module ttsk_stack #(
  parameter int STACK_LEVELS = ttsk_pkg::STACK_LEVELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttsk_pkg::stk_ctl_t ctl_i,
  input  ttsk_pkg::mat_t    cur_i,
  output ttsk_pkg::mat_t    tos_o,
  output ttsk_pkg::stk_sts_t sts_o
);
  import ttsk_pkg::*;

  localparam int AW = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
  localparam int LW = $clog2(STACK_LEVELS + 1);

  mat_t          mem [STACK_LEVELS];
  mat_t          rd_q;
  mat_t          tos_q;
  logic          from_mem_q;
  logic [LW-1:0] level_q;
  logic [AW-1:0] rd_addr;

  assign rd_addr = level_q[AW-1:0] - AW'(2);
  assign sts_o.empty = (level_q == '0);
  assign sts_o.full  = (level_q == LW'(STACK_LEVELS));
  // after a pop the new top comes from the registered read
  assign tos_o = from_mem_q ? rd_q : tos_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[level_q[AW-1:0]] <= cur_i;
    end
    if (ctl_i.pop) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      tos_q <= cur_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= '0;
      from_mem_q <= 1'b0;
    end else if (ctl_i.clear) begin
      level_q <= '0;
    end else if (ctl_i.push) begin
      level_q    <= level_q + LW'(1);
      from_mem_q <= 1'b0;
    end else if (ctl_i.pop) begin
      level_q    <= level_q - LW'(1);
      from_mem_q <= 1'b1;
    end
  end

endmodule

// ----- sv/ttsk_matrix.sv -----
module ttsk_matrix #(
  parameter int FRAC_BITS = ttsk_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  ttsk_pkg::op_e      op_i,
  input  logic [9:0]         tree_offset_i,
  input  logic [30:0]        base_scale_i,
  input  logic signed [31:0] base_x_i,
  input  logic signed [31:0] base_y_i,
  input  ttsk_pkg::mat_t     tos_i,
  output ttsk_pkg::mat_t     cur_o,
  output ttsk_pkg::mat_t     nxt_o
);
  import ttsk_pkg::*;

  localparam logic signed [31:0] K_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] K_SIX = 32'sd6 <<< FRAC_BITS;
  localparam logic signed [31:0] K_COS = from_q30(Q30_COS30, FRAC_BITS);
  localparam logic signed [31:0] K_SIN = from_q30(Q30_SIN30, FRAC_BITS);
  localparam logic signed [31:0] K_SHR = from_q30(Q30_SHRINK, FRAC_BITS);
  localparam logic signed [31:0] K_GRW = from_q30(Q30_GROW, FRAC_BITS);

  mat_t m_q, m_d;
  logic signed [31:0] p, q, u, r, s, v;
  logic do_mul;

  assign cur_o = m_q;
  assign nxt_o = m_d;

  always_comb begin
    p = K_ONE; q = '0; u = '0; r = '0; s = K_ONE; v = '0;
    do_mul = 1'b1;
    case (op_i)
      OP_STEM:  v = K_SIX;
      OP_ROT_P: begin p = K_COS; q = K_SIN;  r = -K_SIN; s = K_COS; end
      OP_ROT_N: begin p = K_COS; q = -K_SIN; r = K_SIN;  s = K_COS; end
      OP_SHR:   begin p = K_SHR; s = K_SHR; end
      OP_GRW:   begin p = K_GRW; s = K_GRW; end
      OP_HSHR:  p = K_SHR;
      OP_HGRW:  p = K_GRW;
      OP_VSHR:  s = K_SHR;
      OP_VGRW:  s = K_GRW;
      default:  do_mul = 1'b0;
    endcase

    m_d = m_q;
    if (op_i == OP_START) begin
      m_d.xx = signed'({1'b0, base_scale_i});
      m_d.xy = '0;
      m_d.yx = '0;
      m_d.yy = -signed'({1'b0, base_scale_i});
      m_d.tx = sat32(64'(base_x_i)
                     + signed'(64'(base_scale_i) * 64'(tree_offset_i)));
      m_d.ty = base_y_i;
    end else if (op_i == OP_POP) begin
      m_d = tos_i;
    end else if (do_mul) begin
      m_d.xx = mac(m_q.xx, p, m_q.xy, r, '0, FRAC_BITS);
      m_d.xy = mac(m_q.xx, q, m_q.xy, s, '0, FRAC_BITS);
      m_d.tx = mac(m_q.xx, u, m_q.xy, v, m_q.tx, FRAC_BITS);
      m_d.yx = mac(m_q.yx, p, m_q.yy, r, '0, FRAC_BITS);
      m_d.yy = mac(m_q.yx, q, m_q.yy, s, '0, FRAC_BITS);
      m_d.ty = mac(m_q.yx, u, m_q.yy, v, m_q.ty, FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q.xx <= signed'({1'b0, BASE_SCALE_RST});
      m_q.xy <= '0;
      m_q.yx <= '0;
      m_q.yy <= -signed'({1'b0, BASE_SCALE_RST});
      m_q.tx <= BASE_X_RST;
      m_q.ty <= BASE_Y_RST;
    end else if (en_i) begin
      m_q <= m_d;
    end
  end

endmodule

// ----- sv/turtle_transform_stack_top.sv -----
// 2D affine turtle for L-system strings. One request per cycle: each accepted
// symbol right-multiplies the current transform by a constant rotation,
// scale or translation, or pushes/pops it on a saved-transform stack; a start
// request reloads the base transform (scale, y flipped, plus tree offset)
// and empties the stack. Every request yields one result: draw kind, the
// transform in force (before the move for T and L, after it otherwise) and a
// stack fault flag. Throughput is one request per clock while the output is
// not stalled, set by the matrix update loop; the result is then registered.
// The stack sits in a one-port-write, one-port-read synchronous memory; the
// top entry is kept in a register and refilled by the read issued on each pop,
// so back-to-back pops and pushes need no stall. Config writes apply at the
// next start. No clearing pass after reset.
module turtle_transform_stack_top #(
  parameter int STACK_LEVELS = ttsk_pkg::STACK_LEVELS_DEF,
  parameter int FRAC_BITS    = ttsk_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ttsk_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [7:0]                    symbol_i,
  input  logic [9:0]                    tree_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    draw_kind_o,
  output logic signed [31:0]            m_xx_o,
  output logic signed [31:0]            m_xy_o,
  output logic signed [31:0]            m_yx_o,
  output logic signed [31:0]            m_yy_o,
  output logic signed [31:0]            m_tx_o,
  output logic signed [31:0]            m_ty_o,
  output logic                          stack_fault_o
);
  import ttsk_pkg::*;

  logic [30:0]        base_scale_q;
  logic signed [31:0] base_x_q, base_y_q;

  logic      acc;
  op_e       op;
  logic      fault;
  logic [1:0] kind;
  stk_ctl_t  stk_ctl;
  stk_sts_t  stk_sts;
  mat_t      cur, nxt, tos, shown;

  logic       out_valid_q;
  logic [1:0] kind_q;
  logic       fault_q;
  mat_t       shown_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_scale_q <= BASE_SCALE_RST;
      base_x_q     <= BASE_X_RST;
      base_y_q     <= BASE_Y_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BASE_SCALE: base_scale_q <= cfg_data_i[30:0];
        CFG_BASE_X:     base_x_q     <= cfg_data_i;
        CFG_BASE_Y:     base_y_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output register frees as soon as its result is taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  // symbol decode; faulting stack ops collapse to no-op
  always_comb begin
    op    = OP_NONE;
    fault = 1'b0;
    kind  = KIND_NONE;
    if (command_i) begin
      op = OP_START;
    end else begin
      unique case (symbol_i)
        SYM_LEAF:   begin op = OP_LEAF; kind = KIND_LEAF; end
        SYM_STEM:   begin op = OP_STEM; kind = KIND_STEM; end
        SYM_PLUS:   op = OP_ROT_P;
        SYM_MINUS:  op = OP_ROT_N;
        SYM_SHRINK: op = OP_SHR;
        SYM_GROW:   op = OP_GRW;
        SYM_HSHR:   op = OP_HSHR;
        SYM_HGRW:   op = OP_HGRW;
        SYM_VSHR:   op = OP_VSHR;
        SYM_VGRW:   op = OP_VGRW;
        SYM_PUSH:   if (stk_sts.full) fault = 1'b1; else op = OP_PUSH;
        SYM_POP:    if (stk_sts.empty) fault = 1'b1; else op = OP_POP;
        default:    op = OP_NONE;
      endcase
    end
  end

  assign stk_ctl.push  = acc && (op == OP_PUSH);
  assign stk_ctl.pop   = acc && (op == OP_POP);
  assign stk_ctl.clear = acc && (op == OP_START);

  assign shown = (kind != KIND_NONE) ? cur : nxt;

  ttsk_stack #(.STACK_LEVELS(STACK_LEVELS)) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (stk_ctl),
    .cur_i  (cur),
    .tos_o  (tos),
    .sts_o  (stk_sts)
  );

  ttsk_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (acc),
    .op_i          (op),
    .tree_offset_i (tree_offset_i),
    .base_scale_i  (base_scale_q),
    .base_x_i      (base_x_q),
    .base_y_i      (base_y_q),
    .tos_i         (tos),
    .cur_o         (cur),
    .nxt_o         (nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      kind_q  <= kind;
      fault_q <= fault;
      shown_q <= shown;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign draw_kind_o   = kind_q;
  assign stack_fault_o = fault_q;
  assign m_xx_o        = shown_q.xx;
  assign m_xy_o        = shown_q.xy;
  assign m_yx_o        = shown_q.yx;
  assign m_yy_o        = shown_q.yy;
  assign m_tx_o        = shown_q.tx;
  assign m_ty_o        = shown_q.ty;

endmodule

// ----- sv/ttsk_checker.sv -----
module ttsk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        command_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  draw_kind_o,
  input logic        stack_fault_o
);
  import ttsk_pkg::*;

  // result register must free whenever downstream takes it
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled with output free");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("request produced no result");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i)
      |=> (draw_kind_o == KIND_NONE && !stack_fault_o))
    else $error("start result not plain");

  a_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stack_fault_o) |-> (draw_kind_o == KIND_NONE))
    else $error("fault with draw");

endmodule

bind turtle_transform_stack_top ttsk_checker u_ttsk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .command_i     (command_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .draw_kind_o   (draw_kind_o),
  .stack_fault_o (stack_fault_o)
);
